### rtl/core/ring_target_score_counter_macros.svh
// ----------------------------------------------------------------------------
// ring target score counter assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RING_TARGET_SCORE_COUNTER_MACROS_SVH
`define RING_TARGET_SCORE_COUNTER_MACROS_SVH

// same-cycle implication
`define RTSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtsc check failed");

// next-cycle implication
`define RTSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtsc check failed");

`endif

### rtl/core/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// rtsc_pkg
// shared widths, operation codes and helpers of the ring target score counter
// ----------------------------------------------------------------------------
package rtsc_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 4096;

    // field widths
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 12;
    localparam int RADIUS_W = 20;
    localparam int COORD_W  = 21;
    localparam int COUNT_W  = 13;
    localparam int TOTAL_W  = 48;
    localparam int ENTRY_W  = 41;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int DIST_W   = PROD_W;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd1;
    localparam logic REG_CIRCLE_COUNT = 1'b0;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SHOT  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // magnitude of a two's complement coordinate, full range fits unsigned
    function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + {{(COORD_W-1){1'b0}}, 1'b1}) : v;
    endfunction

endpackage

### rtl/core/rtsc_ram.sv
// ----------------------------------------------------------------------------
// rtsc_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module rtsc_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/rtsc_square.sv
// ----------------------------------------------------------------------------
// rtsc_square
// shared squaring unit for radii and shot coordinates
// ----------------------------------------------------------------------------
module rtsc_square
    import rtsc_pkg::*;
(
    input  logic [COORD_W-1:0] operand,
    output logic [PROD_W-1:0]  product
);

    // one unsigned 21 x 21 multiply
    assign product = PROD_W'(operand) * PROD_W'(operand);

endmodule

### rtl/core/rtsc_ctrl.sv
// ----------------------------------------------------------------------------
// rtsc_ctrl
// sequencer: squares radii into the table and the shot, binary-searches the table, keeps the total
// ----------------------------------------------------------------------------
module rtsc_ctrl
    import rtsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [INDEX_W-1:0]  circle_index,
    input  logic [RADIUS_W-1:0] radius,
    input  logic [COORD_W-1:0]  shot_x,
    input  logic [COORD_W-1:0]  shot_y,
    input  logic [COUNT_W-1:0]  circle_count,
    output logic [COORD_W-1:0]  sq_operand,
    input  logic [PROD_W-1:0]   sq_product,
    output logic                ram_we,
    output logic [AW-1:0]       ram_addr,
    output logic [ENTRY_W-1:0]  ram_wdata,
    input  logic [ENTRY_W-1:0]  ram_rdata,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COUNT_W-1:0]  shot_score,
    output logic [TOTAL_W-1:0]  running_total
);

`include "ring_target_score_counter_macros.svh"

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SQX  = 3'd2;
    localparam logic [2:0] ST_SQY  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_LAST = 3'd5;
    localparam logic [2:0] ST_CMP  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [RADIUS_W-1:0] rad_reg;
    logic [COORD_W-1:0]  magx_reg, magy_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic [COUNT_W-1:0]  score_reg, score_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  out_score_reg;
    logic [TOTAL_W-1:0]  out_total_reg;

    logic [COUNT_W-1:0]  n_eff;
    logic [AW-1:0]       n_m1;
    logic [AW:0]         mid_sum, next_sum;
    logic [AW-1:0]       mid;
    logic                entry_ge;
    logic                accept;
    logic                out_free;
    logic                idx_ok;
    logic [TOTAL_W:0]    total_sum;

    // effective circle count, saturated at the table depth
    assign n_eff = (32'(circle_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : circle_count;
    assign n_m1  = AW'(n_eff - COUNT_W'(1));

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign idx_ok   = (32'(idx_reg) < TABLE_DEPTH);

    // current probe and its compare
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[AW:1];
    assign entry_ge = ({1'b0, ram_rdata} >= dist_reg);

    // shared squarer operand
    always_comb
    begin
        case (state_reg)
            ST_LOAD: sq_operand = {1'b0, rad_reg};
            ST_SQY:  sq_operand = magy_reg;
            default: sq_operand = magx_reg;
        endcase
    end

    assign ram_we    = (state_reg == ST_LOAD) && idx_ok;
    assign ram_wdata = sq_product[ENTRY_W-1:0];

    // next state, search bounds and ram address
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        score_next = score_reg;
        next_sum   = '0;
        ram_addr   = AW'(idx_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    score_next = '0;
                    if (op == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (op == OP_SHOT)
                    begin
                        state_next = ST_SQX;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_OUT;
            end
            ST_SQX:
            begin
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // fetch the outermost circle
                ram_addr = n_m1;
                if (n_eff == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                lo_next = '0;
                hi_next = n_m1;
                if (!entry_ge)
                begin
                    state_next = ST_OUT;
                end
                else if (n_m1 == '0)
                begin
                    score_next = n_eff;
                    state_next = ST_OUT;
                end
                else
                begin
                    next_sum   = {1'b0, n_m1};
                    ram_addr   = next_sum[AW:1];
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // narrow the range and issue the next probe
                if (entry_ge)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + AW'(1);
                end
                next_sum = {1'b0, lo_next} + {1'b0, hi_next};
                ram_addr = next_sum[AW:1];
                if (lo_next >= hi_next)
                begin
                    score_next = n_eff - COUNT_W'(hi_next);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // saturating add of the score
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(score_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_SHOT)
                begin
                    total_reg <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
                end
                else if (op_reg == OP_CLEAR)
                begin
                    total_reg <= '0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and datapath
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        score_reg <= score_next;
        if (accept)
        begin
            op_reg   <= op;
            idx_reg  <= circle_index;
            rad_reg  <= radius;
            magx_reg <= coord_mag(shot_x);
            magy_reg <= coord_mag(shot_y);
        end
        if ((state_reg == ST_SQX) || (state_reg == ST_SQY))
        begin
            prod_reg <= sq_product;
        end
        if (state_reg == ST_SQY)
        begin
            dist_reg <= prod_reg;
        end
        else if (state_reg == ST_SUM)
        begin
            dist_reg <= dist_reg + prod_reg;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_score_reg <= score_reg;
            if (op_reg == OP_SHOT)
            begin
                out_total_reg <= total_sum[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                    : total_sum[TOTAL_W-1:0];
            end
            else if (op_reg == OP_CLEAR)
            begin
                out_total_reg <= '0;
            end
            else
            begin
                out_total_reg <= total_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign shot_score    = out_score_reg;
    assign running_total = out_total_reg;

    // search range stays open and inside the table while probing
    `RTSC_ASSERT_IMPL(a_range_open, state_reg == ST_CMP, lo_reg < hi_reg)
    `RTSC_ASSERT_IMPL(a_hi_in_count, state_reg == ST_CMP, 32'(hi_reg) < 32'(n_eff))
    // a waiting result is never overwritten
    `RTSC_ASSERT_NEXT(a_out_hold, (state_reg == ST_OUT) && out_valid_reg && out_stall,
                      state_reg == ST_OUT)
    // an accepted word always starts work
    `RTSC_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE)

endmodule

### rtl/core/ring_target_score_counter.sv
// ----------------------------------------------------------------------------
// ring_target_score_counter
// scores shots against a table of squared circle radii, keeps a running total
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  input     in         in_valid / in_stall    op, circle_index, radius, shot_x, shot_y
//  output    out        out_valid / out_stall  shot_score, running_total
//  config    in         apb psel / penable     circle_count at byte address 0
//
//  a shot does one table read and compare per search step.
//  a new word is taken only in idle; a result waits in the output register.
//  rst_n clears the sequencer, the total and circle_count (to 1); the table
//  is not cleared and holds nothing until loaded.
//  a stalled output holds its word and the sequencer waits before writing it.
// ----------------------------------------------------------------------------
module ring_target_score_counter
    import rtsc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [INDEX_W-1:0]  circle_index,
    input  logic [RADIUS_W-1:0] radius,
    input  logic [COORD_W-1:0]  shot_x,
    input  logic [COORD_W-1:0]  shot_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COUNT_W-1:0]  shot_score,
    output logic [TOTAL_W-1:0]  running_total,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0] count_reg;
    logic [COORD_W-1:0] sq_operand;
    logic [PROD_W-1:0]  sq_product;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CIRCLE_COUNT))
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CIRCLE_COUNT) ? PDATA_W'(count_reg) : '0;

    // radius table
    rtsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // shared squarer
    rtsc_square u_square (
        .operand (sq_operand),
        .product (sq_product)
    );

    // sequencer
    rtsc_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .circle_index  (circle_index),
        .radius        (radius),
        .shot_x        (shot_x),
        .shot_y        (shot_y),
        .circle_count  (count_reg),
        .sq_operand    (sq_operand),
        .sq_product    (sq_product),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .shot_score    (shot_score),
        .running_total (running_total)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring target score counter testbench
// drives load, shot, clear and unused words through the valid/stall input,
// predicts every result word from its own copy of the radius table, the
// running total and circle_count, and checks each output word in order.
// the circle count is set over apb between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import rtsc_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int RADIUS_MAX = (1 << RADIUS_W) - 1;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int IDLE_PCT = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS = 200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [INDEX_W-1:0]         slot;
        logic [RADIUS_W-1:0]        radius;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } target_word_t;

    typedef struct {
        logic [COUNT_W-1:0] score;
        logic [TOTAL_W-1:0] total;
    } score_word_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block ports
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op = OP_LOAD;
    logic [INDEX_W-1:0]  circle_index = '0;
    logic [RADIUS_W-1:0] radius = '0;
    logic [COORD_W-1:0]  shot_x = '0;
    logic [COORD_W-1:0]  shot_y = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [COUNT_W-1:0]  shot_score;
    logic [TOTAL_W-1:0]  running_total;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ring_target_score_counter #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .circle_index(circle_index),
        .radius(radius),
        .shot_x(shot_x),
        .shot_y(shot_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .shot_score(shot_score),
        .running_total(running_total),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predicted block state
    logic [ENTRY_W-1:0] ring_sq [DEPTH];
    logic [COUNT_W-1:0] active_circles = COUNT_RESET;
    logic [TOTAL_W-1:0] total_score = '0;

    // pending input words and expected result words
    target_word_t word_q[$];
    score_word_t  score_q[$];
    target_word_t shown_word;
    score_word_t  expected_word;

    int errors = 0;
    int results_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;
    bit no_idle = 1'b0;
    bit in_taken = 1'b0;

    // squared magnitude of a signed coordinate
    function automatic longint unsigned coord_sq(logic signed [COORD_W-1:0] c);
        longint v;
        v = longint'(c);
        if (v < 0)
            v = -v;
        return v * v;
    endfunction

    // lower-bound search: circles whose squared radius is at least reach_sq
    function automatic logic [COUNT_W-1:0] circles_around(longint unsigned reach_sq);
        int n;
        int lo;
        int hi;
        int mid;
        n = int'(active_circles);
        if (n > DEPTH)
            n = DEPTH;
        if (n == 0)
            return '0;
        if (reach_sq > 64'(ring_sq[n - 1]))
            return '0;
        lo = 0;
        hi = n - 1;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (64'(ring_sq[mid]) >= reach_sq)
                hi = mid;
            else
                lo = mid + 1;
        end
        return COUNT_W'(n - hi);
    endfunction

    // update predicted state with one word and return its result
    function automatic score_word_t apply_word(target_word_t w);
        score_word_t r;
        longint unsigned rr;
        longint unsigned sum;
        r.score = '0;
        case (w.op)
            OP_LOAD:
            begin
                rr = 64'(w.radius);
                ring_sq[w.slot] = ENTRY_W'(rr * rr);
            end
            OP_SHOT:
            begin
                r.score = circles_around(coord_sq(w.x) + coord_sq(w.y));
                sum = 64'(total_score) + 64'(r.score);
                if (sum > TOTAL_MAX)
                    sum = TOTAL_MAX;
                total_score = TOTAL_W'(sum);
            end
            OP_CLEAR:
                total_score = '0;
            default:
                ;
        endcase
        r.total = total_score;
        return r;
    endfunction

    // input acceptance and prediction
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            score_q.push_back(apply_word(shown_word));
    end

    // input driver, new word only once the last one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (word_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                shown_word = word_q.pop_front();
                in_valid <= 1'b1;
                op <= shown_word.op;
                circle_index <= shown_word.slot;
                radius <= shown_word.radius;
                shot_x <= shown_word.x;
                shot_y <= shown_word.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall, one long hold while the input side still has words
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (!hold_done && results_seen > 100 && word_q.size() > 20)
        begin
            out_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (score_q.size() == 0)
            begin
                $error("result word with none expected: shot_score %0d running_total %0d",
                       shot_score, running_total);
                errors++;
            end
            else
            begin
                expected_word = score_q.pop_front();
                if (shot_score !== expected_word.score)
                begin
                    $error("shot_score mismatch: expected %0d, got %0d",
                           expected_word.score, shot_score);
                    errors++;
                end
                if (running_total !== expected_word.total)
                begin
                    $error("running_total mismatch: expected %0d, got %0d",
                           expected_word.total, running_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic int clip_coord(int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
    endfunction

    task automatic push_word(logic [OP_W-1:0] code, int slot, int r, int x, int y);
        target_word_t w;
        w.op = code;
        w.slot = INDEX_W'(slot);
        w.radius = RADIUS_W'(r);
        w.x = COORD_W'(x);
        w.y = COORD_W'(y);
        word_q.push_back(w);
    endtask

    // unused fields of every word carry random bits
    task automatic push_load(int slot, int r);
        push_word(OP_LOAD, slot, r, rand_coord(), rand_coord());
    endtask

    task automatic push_shot(int x, int y);
        push_word(OP_SHOT, $urandom_range(0, DEPTH - 1), $urandom_range(0, RADIUS_MAX), x, y);
    endtask

    task automatic push_op(logic [OP_W-1:0] code);
        push_word(code, $urandom_range(0, DEPTH - 1), $urandom_range(0, RADIUS_MAX),
                  rand_coord(), rand_coord());
    endtask

    // wait until every word is taken and every result has come back,
    // checked at the rising edge where the input side is settled
    task automatic wait_drain();
        do
            @(posedge clk);
        while (word_q.size() != 0 || in_valid || score_q.size() != 0);
        @(negedge clk);
    endtask

    // apb write of circle_count, only with the block idle
    task automatic write_count(int value);
        wait_drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_CIRCLE_COUNT) << 2;
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        active_circles = COUNT_W'(value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // load n circles, then shots aimed at the rings mixed with other ops
    task automatic ring_round(int n, int rmax, bit ordered, int shots);
        int radii[$];
        int outer;
        int rr;
        int span;
        int sx;
        int sy;
        int swap;
        int pick;
        write_count(n);
        for (int i = 0; i < n; i++)
            radii.push_back($urandom_range(0, rmax));
        if (ordered)
            radii.sort();
        outer = 0;
        foreach (radii[i])
        begin
            push_load(i, radii[i]);
            if (radii[i] > outer)
                outer = radii[i];
        end
        span = outer + outer / 4 + 2;
        for (int k = 0; k < shots; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                rr = radii[$urandom_range(0, n - 1)];
                case ($urandom_range(0, 3))
                    // exactly on a ring
                    0:
                    begin
                        sx = rr;
                        sy = 0;
                    end
                    // just outside a ring
                    1:
                    begin
                        sx = rr;
                        sy = 1;
                    end
                    default:
                    begin
                        sx = int'($urandom_range(0, 2 * span)) - span;
                        sy = int'($urandom_range(0, 2 * span)) - span;
                    end
                endcase
                if ($urandom_range(0, 1) != 0)
                    sx = -sx;
                if ($urandom_range(0, 1) != 0)
                begin
                    swap = sx;
                    sx = sy;
                    sy = swap;
                end
                push_shot(clip_coord(sx), clip_coord(sy));
            end
            else if (pick < 76)
                push_shot(rand_coord(), rand_coord());
            else if (pick < 84)
            begin
                // reload breaks the ordering now and then
                if ($urandom_range(0, 1) != 0)
                    push_load($urandom_range(0, n - 1), $urandom_range(0, rmax));
                else
                    push_load($urandom_range(0, DEPTH - 1), $urandom_range(0, rmax));
            end
            else if (pick < 92)
                push_op(OP_CLEAR);
            else
                push_op(OP_UNUSED);
        end
    endtask

    // stimulus
    initial
    begin
        int random_words;
        int n;
        int rmax;
        int roll;
        int shots;
        random_words = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one circle after reset: zero radius, then the largest radius
        push_load(0, 0);
        push_shot(0, 0);
        push_shot(1, 0);
        push_shot(COORD_MIN, COORD_MIN);
        push_op(OP_UNUSED);
        push_load(0, RADIUS_MAX);
        push_shot(COORD_MAX, 0);
        push_shot(COORD_MAX, 1);
        push_shot(0, -COORD_MAX);
        push_shot(COORD_MIN, 0);
        push_op(OP_CLEAR);
        push_shot(1, 1);
        push_op(OP_UNUSED);
        push_load(1, 5);
        push_load(DEPTH - 1, RADIUS_MAX);

        // no circles: every shot scores zero
        write_count(0);
        push_shot(0, 0);
        push_shot(COORD_MAX, COORD_MIN);
        push_op(OP_CLEAR);
        push_op(OP_UNUSED);

        // two circles out of order
        write_count(2);
        push_shot(3, 4);
        push_shot(5, 1);

        // a long ring table without idling
        wait_drain();
        no_idle = 1'b1;
        ring_round(256, RADIUS_MAX, 1'b1, 60);
        wait_drain();
        no_idle = 1'b0;

        // counts past the depth: the last slot holds a zero radius, so every
        // shot off the center misses after one table read
        push_load(DEPTH - 1, 0);
        write_count(COUNT_MAX);
        repeat (8) push_shot(rand_coord() | 1, rand_coord());
        write_count(DEPTH + 1);
        repeat (8) push_shot(rand_coord() | 1, rand_coord());

        // random rounds of ring tables and shots
        while (random_words < RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                n = $urandom_range(1, 16);
            else if (roll < 92)
                n = $urandom_range(17, 64);
            else
                n = $urandom_range(65, 128);
            roll = $urandom_range(0, 3);
            if (roll < 2)
                rmax = RADIUS_MAX;
            else if (roll < 3)
                rmax = $urandom_range(1, 1000);
            else
                rmax = $urandom_range(0, 15);
            shots = $urandom_range(10, 30);
            ring_round(n, rmax, $urandom_range(0, 9) != 0, shots);
            random_words += n + shots;
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && score_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rtsc_pkg.sv
rtl/core/rtsc_ram.sv
rtl/core/rtsc_square.sv
rtl/core/rtsc_ctrl.sv
rtl/core/ring_target_score_counter.sv
test/testbench.sv
